@@ rtl/core/tcu_pkg.sv @@
// Package for the triangle center unit: widths, pipeline stage types and the
// per-stage square root and division steps. No dependencies.
package tcu_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int LEN_FRAC   = 16;
    localparam int OUT_W      = 32;

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int SQR_W   = 2 * DIFF_W - 1;
    localparam int SS_W    = 2 * DIFF_W;
    localparam int ROOT_W  = SS_W / 2 + LEN_FRAC;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 2;
    localparam int DEN_W   = SS_W + 2;
    localparam int OPA_W   = DEN_W + 1;
    localparam int OPB_W   = DIFF_W + 1;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int MAG_W   = SUM_W + FRAC_BITS;
    localparam int QUO_W   = OUT_W;
    localparam int HI_W    = MAG_W - QUO_W;
    localparam int CMP_W   = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int NSTAGE  = 3 + ROOT_W + 4 + QUO_W + 1;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic                         func;
        logic signed [COORD_BITS-1:0] p1x;
        logic signed [COORD_BITS-1:0] p1y;
        logic signed [COORD_BITS-1:0] p2x;
        logic signed [COORD_BITS-1:0] p2y;
        logic signed [COORD_BITS-1:0] p3x;
        logic signed [COORD_BITS-1:0] p3y;
    } vtx_t;

    typedef struct packed {
        vtx_t                     v;
        logic signed [DIFF_W-1:0] bx;
        logic signed [DIFF_W-1:0] by;
        logic signed [DIFF_W-1:0] cx;
        logic signed [DIFF_W-1:0] cy;
        logic signed [DIFF_W-1:0] ex;
        logic signed [DIFF_W-1:0] ey;
    } diff_t;

    typedef struct packed {
        vtx_t                     v;
        logic signed [DIFF_W-1:0] bx;
        logic signed [DIFF_W-1:0] by;
        logic signed [DIFF_W-1:0] cx;
        logic signed [DIFF_W-1:0] cy;
        logic [SQR_W-1:0]         bx2;
        logic [SQR_W-1:0]         by2;
        logic [SQR_W-1:0]         cx2;
        logic [SQR_W-1:0]         cy2;
        logic [SQR_W-1:0]         ex2;
        logic [SQR_W-1:0]         ey2;
        logic signed [SS_W-1:0]   cr1;
        logic signed [SS_W-1:0]   cr2;
    } prod_t;

    typedef struct packed {
        vtx_t                     v;
        logic signed [DIFF_W-1:0] bx;
        logic signed [DIFF_W-1:0] by;
        logic signed [DIFF_W-1:0] cx;
        logic signed [DIFF_W-1:0] cy;
        logic [SS_W-1:0]          bb;
        logic [SS_W-1:0]          cc;
        logic signed [DEN_W-1:0]  d;
    } ctx_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] x0;
        logic signed [PROD_W-1:0] x1;
        logic signed [PROD_W-1:0] x2;
        logic signed [PROD_W-1:0] y0;
        logic signed [PROD_W-1:0] y1;
        logic signed [PROD_W-1:0] y2;
        logic signed [DEN_W-1:0]  den;
    } mul_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] nx;
        logic signed [SUM_W-1:0] ny;
        logic signed [DEN_W-1:0] den;
    } sum_t;

    typedef struct packed {
        logic [MAG_W-1:0] magx;
        logic [MAG_W-1:0] magy;
        logic [DEN_W-1:0] dmag;
        logic             negx;
        logic             negy;
        logic             deg;
    } mag_t;

    typedef struct packed {
        logic [DEN_W-1:0] dmag;
        logic             negx;
        logic             negy;
        logic             ovfx;
        logic             ovfy;
        logic             deg;
    } dctx_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] qsh;
    } div_t;

    function automatic sqrt_t sqrt_step(sqrt_t s);
        logic [REM_W+1:0] sh;
        logic [REM_W+1:0] trial;
        sqrt_t            r;
        sh     = {s.rem, s.rad[RAD_W-1 -: 2]};
        trial  = (REM_W+2)'({s.root, 2'b01});
        r.rad  = s.rad << 2;
        if (sh >= trial)
        begin
            r.rem  = REM_W'(sh - trial);
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = REM_W'(sh);
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic div_t div_step(div_t s, logic [DEN_W-1:0] dmag);
        logic [DEN_W:0] sh;
        div_t           r;
        sh = {s.rem, s.qsh[QUO_W-1]};
        if (sh >= {1'b0, dmag})
        begin
            r.rem = DEN_W'(sh - {1'b0, dmag});
            r.qsh = {s.qsh[QUO_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = DEN_W'(sh);
            r.qsh = {s.qsh[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

@@ rtl/core/triangle_center_unit.sv @@
// Triangle circumcenter / incenter unit, fully pipelined.
// Depends on tcu_pkg for widths, stage types and the root and divide steps.
//
//   channel | handshake           | payload
//   input   | in_valid, in_ready  | func, ax, ay, bx_in, by_in, qx, qy
//   output  | out_valid, out_ready| center_x, center_y, degenerate, saturated
//
// One item enters per cycle while the pipeline is not stalled.
// The depth is set by the digit-by-digit square root (one root bit per stage)
// and the restoring divider (one quotient bit per stage).
// All stages advance together; when the output item is not taken, the whole
// pipeline holds and in_ready is low. Reset clears only the valid bits.
module triangle_center_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   func,
    input  logic signed [tcu_pkg::COORD_BITS-1:0]  ax,
    input  logic signed [tcu_pkg::COORD_BITS-1:0]  ay,
    input  logic signed [tcu_pkg::COORD_BITS-1:0]  bx_in,
    input  logic signed [tcu_pkg::COORD_BITS-1:0]  by_in,
    input  logic signed [tcu_pkg::COORD_BITS-1:0]  qx,
    input  logic signed [tcu_pkg::COORD_BITS-1:0]  qy,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [tcu_pkg::OUT_W-1:0]       center_x,
    output logic signed [tcu_pkg::OUT_W-1:0]       center_y,
    output logic                                   degenerate,
    output logic                                   saturated
);
    import tcu_pkg::*;

    logic              en;
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;

    diff_t s1_reg, s1_next;
    prod_t s2_reg, s2_next;
    ctx_t  s3_reg, s3_next;
    sqrt_t sq_init [3];
    sqrt_t sq_reg  [ROOT_W][3];
    ctx_t  cx_reg  [ROOT_W];
    mul_t  mu_reg, mu_next;
    sum_t  su_reg, su_next;
    mag_t  mg_reg, mg_next;
    dctx_t dc_init;
    div_t  dx_init, dy_init;
    dctx_t dc_reg  [QUO_W];
    div_t  dx_reg  [QUO_W];
    div_t  dy_reg  [QUO_W];
    logic signed [OUT_W-1:0] cxo_reg, cxo_next, cyo_reg, cyo_next;
    logic deg_reg, deg_next, sat_reg, sat_next;

    assign en       = !vld_reg[NSTAGE-1] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[NSTAGE-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        s1_next.v.func = func;
        s1_next.v.p1x  = ax;
        s1_next.v.p1y  = ay;
        s1_next.v.p2x  = bx_in;
        s1_next.v.p2y  = by_in;
        s1_next.v.p3x  = qx;
        s1_next.v.p3y  = qy;
        s1_next.bx     = DIFF_W'(bx_in) - DIFF_W'(ax);
        s1_next.by     = DIFF_W'(by_in) - DIFF_W'(ay);
        s1_next.cx     = DIFF_W'(qx) - DIFF_W'(ax);
        s1_next.cy     = DIFF_W'(qy) - DIFF_W'(ay);
        s1_next.ex     = DIFF_W'(qx) - DIFF_W'(bx_in);
        s1_next.ey     = DIFF_W'(qy) - DIFF_W'(by_in);
    end

    always_comb
    begin
        logic signed [SS_W-1:0] t_bx, t_by, t_cx, t_cy, t_ex, t_ey;
        t_bx = s1_reg.bx * s1_reg.bx;
        t_by = s1_reg.by * s1_reg.by;
        t_cx = s1_reg.cx * s1_reg.cx;
        t_cy = s1_reg.cy * s1_reg.cy;
        t_ex = s1_reg.ex * s1_reg.ex;
        t_ey = s1_reg.ey * s1_reg.ey;
        s2_next.v   = s1_reg.v;
        s2_next.bx  = s1_reg.bx;
        s2_next.by  = s1_reg.by;
        s2_next.cx  = s1_reg.cx;
        s2_next.cy  = s1_reg.cy;
        s2_next.bx2 = t_bx[SQR_W-1:0];
        s2_next.by2 = t_by[SQR_W-1:0];
        s2_next.cx2 = t_cx[SQR_W-1:0];
        s2_next.cy2 = t_cy[SQR_W-1:0];
        s2_next.ex2 = t_ex[SQR_W-1:0];
        s2_next.ey2 = t_ey[SQR_W-1:0];
        s2_next.cr1 = s1_reg.bx * s1_reg.cy;
        s2_next.cr2 = s1_reg.by * s1_reg.cx;
    end

    always_comb
    begin
        s3_next.v  = s2_reg.v;
        s3_next.bx = s2_reg.bx;
        s3_next.by = s2_reg.by;
        s3_next.cx = s2_reg.cx;
        s3_next.cy = s2_reg.cy;
        s3_next.bb = SS_W'(s2_reg.bx2) + SS_W'(s2_reg.by2);
        s3_next.cc = SS_W'(s2_reg.cx2) + SS_W'(s2_reg.cy2);
        s3_next.d  = (DEN_W'(s2_reg.cr1) - DEN_W'(s2_reg.cr2)) <<< 1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    // The |BQ| sum is not part of the stage three context, so it is held in a
    // register that runs beside stage three.
    logic [SS_W-1:0] ee_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ee_reg <= SS_W'(s2_reg.ex2) + SS_W'(s2_reg.ey2);
        end
    end

    // The three side lengths: lane 0 is |AB|, lane 1 is |BQ|, lane 2 is |QA|.
    always_comb
    begin
        sq_init[0].rad  = {s3_reg.bb, {(2*LEN_FRAC){1'b0}}};
        sq_init[1].rad  = {ee_reg, {(2*LEN_FRAC){1'b0}}};
        sq_init[2].rad  = {s3_reg.cc, {(2*LEN_FRAC){1'b0}}};
        for (int i = 0; i < 3; i++)
        begin
            sq_init[i].rem  = '0;
            sq_init[i].root = '0;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_root
        sqrt_t src [3];
        ctx_t  csrc;
        if (k == 0)
        begin : g_first
            always_comb
            begin
                src  = sq_init;
                csrc = s3_reg;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                src  = sq_reg[k-1];
                csrc = cx_reg[k-1];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_reg[k][i] <= sqrt_step(src[i]);
                end
                cx_reg[k] <= csrc;
            end
        end
    end

    always_comb
    begin
        ctx_t                    c;
        logic [ROOT_W-1:0]       la, lb, lc;
        logic [DEN_W-1:0]        per;
        logic signed [OPA_W-1:0] a0, a1, a2, ay0, ay1, ay2;
        logic signed [OPB_W-1:0] b0, b1, b2, by0, by1, by2;
        c   = cx_reg[ROOT_W-1];
        la  = sq_reg[ROOT_W-1][0].root;
        lb  = sq_reg[ROOT_W-1][1].root;
        lc  = sq_reg[ROOT_W-1][2].root;
        per = DEN_W'(la) + DEN_W'(lb) + DEN_W'(lc);
        if (c.v.func)
        begin
            a0  = $signed(OPA_W'(la));
            a1  = $signed(OPA_W'(lb));
            a2  = $signed(OPA_W'(lc));
            b0  = OPB_W'(c.v.p3x);
            b1  = OPB_W'(c.v.p1x);
            b2  = OPB_W'(c.v.p2x);
            ay0 = a0;
            ay1 = a1;
            ay2 = a2;
            by0 = OPB_W'(c.v.p3y);
            by1 = OPB_W'(c.v.p1y);
            by2 = OPB_W'(c.v.p2y);
            mu_next.den = $signed(per);
        end
        else
        begin
            a0  = $signed(OPA_W'(c.bb));
            a1  = $signed(OPA_W'(c.cc));
            a2  = OPA_W'(c.d);
            b0  = OPB_W'(c.cy);
            b1  = -OPB_W'(c.by);
            b2  = OPB_W'(c.v.p1x);
            ay0 = $signed(OPA_W'(c.cc));
            ay1 = $signed(OPA_W'(c.bb));
            ay2 = OPA_W'(c.d);
            by0 = OPB_W'(c.bx);
            by1 = -OPB_W'(c.cx);
            by2 = OPB_W'(c.v.p1y);
            mu_next.den = c.d;
        end
        mu_next.x0 = a0 * b0;
        mu_next.x1 = a1 * b1;
        mu_next.x2 = a2 * b2;
        mu_next.y0 = ay0 * by0;
        mu_next.y1 = ay1 * by1;
        mu_next.y2 = ay2 * by2;
    end

    always_comb
    begin
        su_next.nx  = SUM_W'(mu_reg.x0) + SUM_W'(mu_reg.x1) + SUM_W'(mu_reg.x2);
        su_next.ny  = SUM_W'(mu_reg.y0) + SUM_W'(mu_reg.y1) + SUM_W'(mu_reg.y2);
        su_next.den = mu_reg.den;
    end

    always_comb
    begin
        logic [SUM_W-1:0] ax_m, ay_m;
        ax_m = su_reg.nx[SUM_W-1] ? SUM_W'(-su_reg.nx) : SUM_W'(su_reg.nx);
        ay_m = su_reg.ny[SUM_W-1] ? SUM_W'(-su_reg.ny) : SUM_W'(su_reg.ny);
        mg_next.magx = MAG_W'(ax_m) << FRAC_BITS;
        mg_next.magy = MAG_W'(ay_m) << FRAC_BITS;
        mg_next.dmag = su_reg.den[DEN_W-1] ? DEN_W'(-su_reg.den) : DEN_W'(su_reg.den);
        mg_next.negx = su_reg.nx[SUM_W-1] ^ su_reg.den[DEN_W-1];
        mg_next.negy = su_reg.ny[SUM_W-1] ^ su_reg.den[DEN_W-1];
        mg_next.deg  = (su_reg.den == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mu_reg <= mu_next;
            su_reg <= su_next;
            mg_reg <= mg_next;
        end
    end

    // A quotient of 2^QUO_W or more is caught up front by comparing the high
    // part of the numerator with the divisor; the low bits come one per stage.
    always_comb
    begin
        logic [HI_W-1:0] hx, hy;
        hx = mg_reg.magx[MAG_W-1:QUO_W];
        hy = mg_reg.magy[MAG_W-1:QUO_W];
        dc_init.dmag = mg_reg.dmag;
        dc_init.negx = mg_reg.negx;
        dc_init.negy = mg_reg.negy;
        dc_init.deg  = mg_reg.deg;
        dc_init.ovfx = CMP_W'(hx) >= CMP_W'(mg_reg.dmag);
        dc_init.ovfy = CMP_W'(hy) >= CMP_W'(mg_reg.dmag);
        dx_init.rem  = DEN_W'(hx);
        dx_init.qsh  = mg_reg.magx[QUO_W-1:0];
        dy_init.rem  = DEN_W'(hy);
        dy_init.qsh  = mg_reg.magy[QUO_W-1:0];
    end

    dctx_t dc_p_reg;
    div_t  dx_p_reg, dy_p_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dc_p_reg <= dc_init;
            dx_p_reg <= dx_init;
            dy_p_reg <= dy_init;
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        dctx_t csrc;
        div_t  xs, ys;
        if (k == 0)
        begin : g_first
            always_comb
            begin
                csrc = dc_p_reg;
                xs   = dx_p_reg;
                ys   = dy_p_reg;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                csrc = dc_reg[k-1];
                xs   = dx_reg[k-1];
                ys   = dy_reg[k-1];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dc_reg[k] <= csrc;
                dx_reg[k] <= div_step(xs, csrc.dmag);
                dy_reg[k] <= div_step(ys, csrc.dmag);
            end
        end
    end

    always_comb
    begin
        dctx_t            c;
        logic [QUO_W-1:0] qxv, qyv;
        logic             sx, sy;
        c   = dc_reg[QUO_W-1];
        qxv = dx_reg[QUO_W-1].qsh;
        qyv = dy_reg[QUO_W-1].qsh;
        sx  = c.ovfx || (c.negx ? (qxv[QUO_W-1] && (|qxv[QUO_W-2:0])) : qxv[QUO_W-1]);
        sy  = c.ovfy || (c.negy ? (qyv[QUO_W-1] && (|qyv[QUO_W-2:0])) : qyv[QUO_W-1]);
        if (c.deg)
        begin
            cxo_next = '0;
            cyo_next = '0;
            sat_next = 1'b0;
        end
        else
        begin
            if (sx)
                cxo_next = c.negx ? OUT_MIN : OUT_MAX;
            else
                cxo_next = c.negx ? $signed(OUT_W'(-qxv)) : $signed(OUT_W'(qxv));
            if (sy)
                cyo_next = c.negy ? OUT_MIN : OUT_MAX;
            else
                cyo_next = c.negy ? $signed(OUT_W'(-qyv)) : $signed(OUT_W'(qyv));
            sat_next = sx || sy;
        end
        deg_next = c.deg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cxo_reg <= cxo_next;
            cyo_reg <= cyo_next;
            deg_reg <= deg_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid  = vld_reg[NSTAGE-1];
    assign center_x   = cxo_reg;
    assign center_y   = cyo_reg;
    assign degenerate = deg_reg;
    assign saturated  = sat_reg;

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> center_x == '0 && center_y == '0 && !saturated)
        else $error("degenerate item carries a nonzero center");

    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            center_x == OUT_MIN || center_x == OUT_MAX ||
            center_y == OUT_MIN || center_y == OUT_MAX)
        else $error("saturated item has no clamped coordinate");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with an empty output stage");

endmodule
